>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define ASSERT_CLK_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/bwbu_pkg.sv
// Shared constants and the cumulative binomial count function for the unranker.
`timescale 1ns / 1ps

package bwbu_pkg;

   localparam int WORD_W  = 31;   // generated word width
   localparam int RANK_W  = 32;   // rank width
   localparam int CFG_W   = 5;    // bit_count / max_ones width
   localparam int DATA_W  = 32;   // csr data width
   localparam int ADDR_W  = 3;    // csr byte address width
   localparam int BUD_N   = 1 << CFG_W;  // budget values

   localparam logic [CFG_W-1:0] RST_BIT_COUNT = 5'd31;
   localparam logic [CFG_W-1:0] RST_MAX_ONES  = 5'd31;

   // register index codes (byte address bit 2)
   localparam logic REG_BIT_COUNT = 1'b0;
   localparam logic REG_MAX_ONES  = 1'b1;

   // Number of n-bit words with at most l ones; used at elaboration only.
   function automatic logic [RANK_W-1:0] cum_count(input int n, input int l);
      logic [RANK_W:0] row [0:WORD_W];
      logic [RANK_W:0] sum;
      int i;
      int k;
      for (k = 0; k <= WORD_W; k++) begin
         row[k] = '0;
      end
      row[0] = (RANK_W+1)'(1);
      for (i = 1; i <= n; i++) begin
         for (k = i; k >= 1; k--) begin
            row[k] = row[k] + row[k-1];
         end
      end
      sum = '0;
      for (k = 0; k <= WORD_W; k++) begin
         if (k <= l && k <= n) begin
            sum = sum + row[k];
         end
      end
      return sum[RANK_W-1:0];
   endfunction

endpackage

>>> rtl/bounded_weight_binary_unrank.sv
// Top level of the bounded-weight binary unranker: csr block and bit pipeline.
`timescale 1ns / 1ps

// Bounded-weight binary unranker.
// A request carries a one-based rank on req_tdata. The response gives the
// word of that rank, in ascending order, among all bit_count-bit words with
// at most max_ones ones; rsp_tuser flags a rank of zero or above the word
// count, and the word then reads zero.
// bit_count and max_ones sit in two csr registers (byte addresses 0 and 4),
// written over the APB-style port; the user must write them only while no
// request is in flight; the block does not enforce it. Pipeline: one capture
// stage, one stage per bit position (MAX_BITS capped at the 31-bit word, top
// position first), and an output register; a new request enters every cycle
// unless the receiver stalls. Each bit stage looks up a 32-entry constant
// count table by the remaining budget, then one 32-bit compare and subtract.
// Reset empties the pipeline and restores bit_count = 31, max_ones = 31.
// A receiver stall freezes the whole pipeline and drops req_tready; nothing
// is lost or repeated.
module bounded_weight_binary_unrank
   import bwbu_pkg::*;
#(
   parameter int MAX_BITS = 31
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [RANK_W-1:0]     req_tdata,    // [31:0] rank
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [DATA_W-1:0]     rsp_tdata,    // [30:0] word, [31] zero pad
   output logic                  rsp_tuser,    // [0] out_of_range
   // csr port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [ADDR_W-1:0]     csr_paddr,
   input  logic [DATA_W-1:0]     csr_pwdata,
   output logic [DATA_W-1:0]     csr_prdata,
   output logic                  csr_pready
);

   // bit stages: one per position, no more than the word holds
   localparam int NSTG = (MAX_BITS < WORD_W) ? MAX_BITS : WORD_W;

   // ---------------- csr registers ----------------
   logic [CFG_W-1:0] bit_count_ff;
   logic [CFG_W-1:0] max_ones_ff;
   logic             csr_wr;
   logic [5:0]       n_eff;   // bit count clamped to the stage count

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_count_ff <= RST_BIT_COUNT;
         max_ones_ff  <= RST_MAX_ONES;
      end else if (csr_wr) begin
         case (csr_paddr[ADDR_W-1])
            REG_BIT_COUNT: bit_count_ff <= csr_pwdata[CFG_W-1:0];
            REG_MAX_ONES:  max_ones_ff  <= csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[ADDR_W-1])
         REG_BIT_COUNT: csr_prdata = DATA_W'(bit_count_ff);
         REG_MAX_ONES:  csr_prdata = DATA_W'(max_ones_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign n_eff = ({1'b0, bit_count_ff} > 6'(NSTG)) ? 6'(NSTG) : {1'b0, bit_count_ff};

   // ---------------- pipeline ----------------
   // Stage 0 captures the request; stage s decides bit NSTG-s.
   logic                 valid_ff  [0:NSTG];
   logic [RANK_W-1:0]    rank_ff   [0:NSTG];
   logic [CFG_W-1:0]     budget_ff [0:NSTG];
   logic [WORD_W-1:0]    word_ff   [0:NSTG];
   logic [RANK_W-1:0]    rank_in   [1:NSTG];
   logic [CFG_W-1:0]     budget_in [1:NSTG];
   logic [WORD_W-1:0]    word_in   [1:NSTG];

   logic                 rsp_valid_ff;
   logic [WORD_W-1:0]    rsp_word_ff;
   logic                 rsp_oor_ff;
   logic                 advance;
   logic                 oor_in;

   // whole pipeline moves together unless the held response is stalled
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   genvar s;
   generate
      for (s = 1; s <= NSTG; s++) begin : g_bit
         localparam int POS = NSTG - s;
         logic [RANK_W-1:0] cnt_tab [0:BUD_N-1];
         logic [RANK_W-1:0] cnt;
         logic              take;
         genvar k;
         for (k = 0; k < BUD_N; k++) begin : g_tab
            assign cnt_tab[k] = cum_count(POS, k);
         end
         // words below the current prefix if this bit stays clear
         always_comb begin
            cnt  = cnt_tab[budget_ff[s-1]];
            take = (6'(POS) < n_eff) && (rank_ff[s-1] > cnt) && (budget_ff[s-1] != '0);
            rank_in[s]   = take ? (rank_ff[s-1] - cnt) : rank_ff[s-1];
            budget_in[s] = take ? (budget_ff[s-1] - CFG_W'(1)) : budget_ff[s-1];
            word_in[s]      = word_ff[s-1];
            word_in[s][POS] = take;
         end
      end
   endgenerate

   // a valid rank leaves exactly one behind; anything else was out of range
   assign oor_in = (rank_ff[NSTG] != RANK_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= NSTG; i++) begin
            valid_ff[i] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= req_tvalid;
         for (int i = 1; i <= NSTG; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
         rsp_valid_ff <= valid_ff[NSTG];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rank_ff[0]   <= req_tdata;
         budget_ff[0] <= max_ones_ff;
         word_ff[0]   <= '0;
         for (int i = 1; i <= NSTG; i++) begin
            rank_ff[i]   <= rank_in[i];
            budget_ff[i] <= budget_in[i];
            word_ff[i]   <= word_in[i];
         end
         rsp_word_ff <= oor_in ? '0 : word_ff[NSTG];
         rsp_oor_ff  <= oor_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'(rsp_word_ff);
   assign rsp_tuser  = rsp_oor_ff;

endmodule

>>> rtl/bwbu_checker.sv
// Port-level checks for the unranker, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bwbu_checker
   import bwbu_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tready,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [DATA_W-1:0]    rsp_tdata,
   input logic                 rsp_tuser
);

   // out-of-range response carries an all-zero word
   property p_oor_zero;
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0;
   endproperty

   // pipeline never blocks requests while the receiver takes responses
   property p_ready_follow;
      rsp_tready |-> req_tready;
   endproperty

   // stalled response holds
   property p_rsp_hold;
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser);
   endproperty

   `ASSERT_CLK(a_oor_zero, clock, reset, p_oor_zero, "out_of_range with nonzero word")
   `ASSERT_CLK(a_ready_follow, clock, reset, p_ready_follow, "request stalled needlessly")
   `ASSERT_CLK(a_rsp_hold, clock, reset, p_rsp_hold, "stalled response changed")

   // reset empties the pipeline
   `ASSERT_CLK_NR(a_reset_empty, clock, reset |=> !rsp_tvalid, "response valid after reset")

endmodule

bind bounded_weight_binary_unrank bwbu_checker u_bwbu_checker (.*);
